[hdl/sds_pkg.sv]
// Shared types and constants for the SAD stereo disparity search unit.
// No dependencies; used by the top level, sds_cell and sds_best.
package sds_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_ECHK,
    ST_RUN,
    ST_WAIT,
    ST_FIN
  } state_t;

  // Control token that travels down the cell chain with each window row
  typedef struct packed {
    logic valid;
    logic first;  // first window row of a candidate
    logic last;   // last window row of a candidate
    logic fin;    // last row of the last candidate
  } token_t;

  // Configuration register indexes
  localparam logic [2:0] REG_WINDOW = 3'd0;
  localparam logic [2:0] REG_DMIN   = 3'd1;
  localparam logic [2:0] REG_DMAX   = 3'd2;
  localparam logic [2:0] REG_VRANGE = 3'd3;
  localparam logic [2:0] REG_THRESH = 3'd4;
  localparam logic [2:0] REG_WIDTH  = 3'd5;
  localparam logic [2:0] REG_HEIGHT = 3'd6;

  // Register reset values
  localparam logic [4:0]  RST_WINDOW = 5'd8;
  localparam logic [6:0]  RST_DMIN   = 7'd0;
  localparam logic [6:0]  RST_DMAX   = 7'd16;
  localparam logic [2:0]  RST_VRANGE = 3'd0;
  localparam logic [7:0]  RST_THRESH = 8'd0;
  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [10:0] RST_HEIGHT = 11'd480;

  // Best score starts here; a candidate must be strictly lower
  localparam logic [15:0] SCORE_START = 16'd65532;

endpackage

[hdl/sad_stereo_disparity_search_unit.sv]
// Top level of the SAD stereo disparity search unit: counters, sequencer,
// cell chain. Depends on sds_pkg, sds_store, sds_cell and sds_best.
//
// Use: one input beat per pixel in raster order (left, right, edge values),
// valid/stall on both channels; a configuration write port (cfg_valid,
// cfg_ready, cfg_index, cfg_data) that is always ready; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A pixel that completes no map entry does not stall the input. A pixel that
// completes an entry whose edge value is at or below the threshold gives its
// default result through the states EDGE, ECHK and FIN into the output
// register; the next pixel is taken once the sequencer is back in IDLE. For
// a searched entry, the line store read port delivers one left/right pixel pair
// per cycle to a chain of MAX_WINDOW cells; each cell adds one window column.
// in_stall is high while an entry is being worked on. The result sits in an
// output register; the next pixel is taken while it waits on out_stall, and
// only a further result holds the block until the waiting beat is taken.
// Reset clears counters, sequencer and output valid and restores register
// defaults; the line stores are not cleared and need no clearing pass.
module sad_stereo_disparity_search_unit #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int MAX_WINDOW    = 16,
  parameter int MAX_DISPARITY = 64,
  parameter int MAX_VERTICAL  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_left_pixel,
  input  logic [7:0]        in_right_pixel,
  input  logic [7:0]        in_edge_strength,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [9:0]        out_row,
  output logic [9:0]        out_col,
  output logic signed [7:0] out_disparity_x,
  output logic [3:0]        out_vertical_offset,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [10:0]       cfg_data
);

  localparam int SR  = MAX_WINDOW + 2 * MAX_VERTICAL;
  localparam int SRW = (SR > 1) ? $clog2(SR) : 1;
  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int RLW = $clog2(MAX_HEIGHT);
  localparam int PW  = $clog2(MAX_WIDTH + MAX_HEIGHT + 4 * MAX_DISPARITY +
                              4 * MAX_WINDOW + 4 * MAX_VERTICAL + 4096) + 2;
  localparam int WW  = $clog2(MAX_WINDOW + 1);
  localparam int UW  = $clog2(2 * MAX_VERTICAL + 1) + 4;
  localparam int SW  = $clog2(MAX_WINDOW * 255 + 1);

  function automatic logic [SRW-1:0] slot_row(input logic signed [PW-1:0] base,
                                              input logic signed [PW-1:0] off);
    logic signed [PW-1:0] t;
    t = PW'(base + off);
    if (t < 0) t = PW'(t + SR);
    return t[SRW-1:0];
  endfunction

  // configuration registers
  logic [4:0]  cfg_win_r;
  logic [6:0]  cfg_dmin_r, cfg_dmax_r;
  logic [2:0]  cfg_vr_r;
  logic [7:0]  cfg_th_r;
  logic [10:0] cfg_width_r, cfg_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_win_r    <= sds_pkg::RST_WINDOW;
      cfg_dmin_r   <= sds_pkg::RST_DMIN;
      cfg_dmax_r   <= sds_pkg::RST_DMAX;
      cfg_vr_r     <= sds_pkg::RST_VRANGE;
      cfg_th_r     <= sds_pkg::RST_THRESH;
      cfg_width_r  <= sds_pkg::RST_WIDTH;
      cfg_height_r <= sds_pkg::RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sds_pkg::REG_WINDOW: cfg_win_r    <= cfg_data[4:0];
        sds_pkg::REG_DMIN:   cfg_dmin_r   <= cfg_data[6:0];
        sds_pkg::REG_DMAX:   cfg_dmax_r   <= cfg_data[6:0];
        sds_pkg::REG_VRANGE: cfg_vr_r     <= cfg_data[2:0];
        sds_pkg::REG_THRESH: cfg_th_r     <= cfg_data[7:0];
        sds_pkg::REG_WIDTH:  cfg_width_r  <= cfg_data;
        sds_pkg::REG_HEIGHT: cfg_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped register values
  logic signed [PW-1:0] win_raw, dmin_raw, dmax_raw, vr_raw, wid_raw, hgt_raw;
  logic signed [PW-1:0] w_s, dmin, dmax, up, width_s, height_s, k_s;

  always_comb begin
    win_raw  = $signed(PW'(cfg_win_r));
    dmin_raw = PW'($signed(cfg_dmin_r));
    dmax_raw = $signed(PW'(cfg_dmax_r));
    vr_raw   = $signed(PW'(cfg_vr_r));
    wid_raw  = $signed(PW'(cfg_width_r));
    hgt_raw  = $signed(PW'(cfg_height_r));
    w_s      = (win_raw < 1) ? PW'(1) :
               (win_raw > MAX_WINDOW) ? PW'(MAX_WINDOW) : win_raw;
    dmin     = (dmin_raw < -MAX_DISPARITY) ? PW'(-MAX_DISPARITY) :
               (dmin_raw > 0) ? PW'(0) : dmin_raw;
    dmax     = (dmax_raw > MAX_DISPARITY) ? PW'(MAX_DISPARITY) : dmax_raw;
    up       = (vr_raw > MAX_VERTICAL) ? PW'(MAX_VERTICAL) : vr_raw;
    width_s  = (wid_raw < 1) ? PW'(1) :
               (wid_raw > MAX_WIDTH) ? PW'(MAX_WIDTH) : wid_raw;
    height_s = (hgt_raw < 1) ? PW'(1) :
               (hgt_raw > MAX_HEIGHT) ? PW'(MAX_HEIGHT) : hgt_raw;
    k_s      = PW'(w_s + 2 * up - 1);
  end

  // pixel position counters and map entry check
  logic [CLW-1:0]       col_r;
  logic [RLW-1:0]       row_r;
  logic [SRW-1:0]       rm_r, rm0_r;
  logic signed [PW-1:0] col_s, row_s, i_now, j_now, i_r, j_r;
  logic                 accept, emit;
  sds_pkg::state_t      state_r, state_nxt;

  assign in_stall = (state_r != sds_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign col_s    = $signed(PW'(col_r));
  assign row_s    = $signed(PW'(row_r));
  assign i_now    = PW'(row_s - k_s);
  assign j_now    = PW'(col_s - (w_s + dmax - 1));
  assign emit     = (i_now >= 0) && (j_now >= -dmin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      rm_r  <= '0;
    end else if (accept) begin
      if (PW'(col_s + 1) >= width_s) begin
        col_r <= '0;
        if (PW'(row_s + 1) >= height_s) begin
          row_r <= '0;
          rm_r  <= '0;
        end else begin
          row_r <= RLW'(row_r + 1'b1);
          rm_r  <= (int'(rm_r) == SR - 1) ? '0 : SRW'(rm_r + 1'b1);
        end
      end else begin
        col_r <= CLW'(col_r + 1'b1);
      end
    end
    if (accept) begin
      i_r   <= i_now;
      j_r   <= j_now;
      rm0_r <= rm_r;
    end
  end

  // search sequencer
  logic [UW-1:0]        ud_r, ud_nxt;
  logic signed [PW-1:0] d_r, d_nxt;
  logic [WW-1:0]        a_r, a_nxt, b_r, b_nxt;
  logic signed [PW-1:0] a_s, b_s, base_s;
  logic                 b_last, a_last, d_last, ud_last;
  logic                 best_init, ld_out, done;
  logic [7:0]           left_q, right_q, edge_q;

  assign a_s     = $signed(PW'(a_r));
  assign b_s     = $signed(PW'(b_r));
  assign base_s  = PW'($signed(PW'(rm0_r)) - k_s);
  assign b_last  = (b_s == PW'(w_s - 1));
  assign a_last  = (a_s == PW'(w_s - 1));
  assign d_last  = (d_r == dmax);
  assign ud_last = ($signed(PW'(ud_r)) == PW'(2 * up));

  always_comb begin
    state_nxt = state_r;
    ud_nxt    = ud_r;
    d_nxt     = d_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    best_init = 1'b0;
    ld_out    = 1'b0;
    case (state_r)
      sds_pkg::ST_IDLE: begin
        if (accept && emit) state_nxt = sds_pkg::ST_EDGE;
      end
      sds_pkg::ST_EDGE: begin
        state_nxt = sds_pkg::ST_ECHK;
      end
      sds_pkg::ST_ECHK: begin
        best_init = 1'b1;
        ud_nxt    = '0;
        d_nxt     = dmin;
        a_nxt     = '0;
        b_nxt     = '0;
        state_nxt = (edge_q > cfg_th_r) ? sds_pkg::ST_RUN : sds_pkg::ST_FIN;
      end
      sds_pkg::ST_RUN: begin
        if (b_last) begin
          b_nxt = '0;
          if (a_last) begin
            a_nxt = '0;
            if (d_last) begin
              d_nxt = dmin;
              if (ud_last) state_nxt = sds_pkg::ST_WAIT;
              else ud_nxt = UW'(ud_r + 1'b1);
            end else begin
              d_nxt = PW'(d_r + 1);
            end
          end else begin
            a_nxt = WW'(a_r + 1'b1);
          end
        end else begin
          b_nxt = WW'(b_r + 1'b1);
        end
      end
      sds_pkg::ST_WAIT: begin
        if (done) state_nxt = sds_pkg::ST_FIN;
      end
      sds_pkg::ST_FIN: begin
        if (!out_valid || !out_stall) begin
          ld_out    = 1'b1;
          state_nxt = sds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ud_r <= ud_nxt;
    d_r  <= d_nxt;
    a_r  <= a_nxt;
    b_r  <= b_nxt;
  end

  // read addresses: one left/right pair per cycle, edge at the entry itself
  logic signed [PW-1:0] lc_s, rc_s;
  logic [SRW-1:0]       lrow, rrow, erow;
  logic [CLW-1:0]       lcol, rcol;

  assign lc_s = PW'(j_r + dmin + b_s);
  assign rc_s = PW'(lc_s + d_r);
  assign lrow = slot_row(base_s, PW'(up + a_s));
  assign rrow = slot_row(base_s, PW'($signed(PW'(ud_r)) + a_s));
  assign erow = slot_row(base_s, '0);
  assign lcol = lc_s[CLW-1:0];
  assign rcol = (rc_s < 0) ? '0 : rc_s[CLW-1:0];

  sds_store #(.ROWS(SR), .COLS(MAX_WIDTH)) u_store (
    .clk      (clk),
    .wr_en    (accept),
    .wr_row   (rm_r),
    .wr_col   (col_r),
    .wr_left  (in_left_pixel),
    .wr_right (in_right_pixel),
    .wr_edge  (in_edge_strength),
    .lrd_row  (lrow),
    .lrd_col  (lcol),
    .rrd_row  (rrow),
    .rrd_col  (rcol),
    .erd_row  (erow),
    .erd_col  (j_r[CLW-1:0]),
    .left_q   (left_q),
    .right_q  (right_q),
    .edge_q   (edge_q)
  );

  // row token injected in step with the read data of column zero
  sds_pkg::token_t inj_r;
  logic            rzero_r;
  logic [7:0]      diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_r <= '0;
    end else begin
      inj_r.valid <= (state_r == sds_pkg::ST_RUN) && (b_r == '0);
      inj_r.first <= (a_r == '0);
      inj_r.last  <= a_last;
      inj_r.fin   <= a_last && d_last && ud_last;
    end
    rzero_r <= (rc_s < 0);
  end

  // columns left of the image read as zero on the right side
  always_comb begin
    if (rzero_r) diff = left_q;
    else if (left_q > right_q) diff = 8'(left_q - right_q);
    else diff = 8'(right_q - left_q);
  end

  // cell chain
  sds_pkg::token_t tok_chain [MAX_WINDOW+1];
  logic [SW-1:0]   sum_chain [MAX_WINDOW+1];

  assign tok_chain[0] = inj_r;
  assign sum_chain[0] = '0;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    sds_cell #(.IDX(g), .SW(SW), .WW(WW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .win     (w_s[WW-1:0]),
      .tok_in  (tok_chain[g]),
      .sum_in  (sum_chain[g]),
      .diff    (diff),
      .tok_out (tok_chain[g+1]),
      .sum_out (sum_chain[g+1])
    );
  end

  logic signed [PW-1:0] best_d;
  logic [UW-1:0]        best_ud;

  sds_best #(.PW(PW), .SW(SW), .UW(UW), .MAX_WINDOW(MAX_WINDOW)) u_best (
    .clk     (clk),
    .rst_n   (rst_n),
    .init    (best_init),
    .dmin    (dmin),
    .dmax    (dmax),
    .up      (up),
    .tok     (tok_chain[MAX_WINDOW]),
    .sum     (sum_chain[MAX_WINDOW]),
    .best_d  (best_d),
    .best_ud (best_ud),
    .done    (done)
  );

  // output register
  logic              out_valid_r;
  logic [9:0]        out_row_r, out_col_r;
  logic signed [7:0] out_disp_r;
  logic [3:0]        out_voff_r;
  logic signed [PW-1:0] col_out;

  assign col_out = PW'(j_r + dmin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (ld_out) begin
      out_row_r  <= i_r[9:0];
      out_col_r  <= col_out[9:0];
      out_disp_r <= best_d[7:0];
      out_voff_r <= best_ud[3:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_row             = out_row_r;
  assign out_col             = out_col_r;
  assign out_disparity_x     = out_disp_r;
  assign out_vertical_offset = out_voff_r;

endmodule

[hdl/sds_store.sv]
// Line stores for left, right and edge pixels, one row slot per stored line.
// Depends on nothing; instantiated by the top level.
module sds_store #(
  parameter int ROWS = 24,
  parameter int COLS = 1024,
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [RW-1:0]       wr_row,
  input  logic [CW-1:0]       wr_col,
  input  logic [7:0]          wr_left,
  input  logic [7:0]          wr_right,
  input  logic [7:0]          wr_edge,
  input  logic [RW-1:0]       lrd_row,
  input  logic [CW-1:0]       lrd_col,
  input  logic [RW-1:0]       rrd_row,
  input  logic [CW-1:0]       rrd_col,
  input  logic [RW-1:0]       erd_row,
  input  logic [CW-1:0]       erd_col,
  output logic [7:0]          left_q,
  output logic [7:0]          right_q,
  output logic [7:0]          edge_q
);

  logic [7:0] left_mem  [ROWS][COLS];
  logic [7:0] right_mem [ROWS][COLS];
  logic [7:0] edge_mem  [ROWS][COLS];

  // one write port, registered read per store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_row][wr_col]  <= wr_left;
      right_mem[wr_row][wr_col] <= wr_right;
      edge_mem[wr_row][wr_col]  <= wr_edge;
    end
    left_q  <= left_mem[lrd_row][lrd_col];
    right_q <= right_mem[rrd_row][rrd_col];
    edge_q  <= edge_mem[erd_row][erd_col];
  end

endmodule

[hdl/sds_cell.sv]
// One cell of the SAD chain: adds the broadcast difference of its column.
// Depends on sds_pkg (token_t).
module sds_cell #(
  parameter int IDX = 0,
  parameter int SW  = 12,
  parameter int WW  = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [WW-1:0]         win,
  input  sds_pkg::token_t       tok_in,
  input  logic [SW-1:0]         sum_in,
  input  logic [7:0]            diff,
  output sds_pkg::token_t       tok_out,
  output logic [SW-1:0]         sum_out
);

  sds_pkg::token_t tok_r;
  logic [SW-1:0]   sum_r;
  logic            use_diff;

  // cells past the window width just pass the row sum on
  assign use_diff = tok_in.valid && (int'(win) > IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
    sum_r <= use_diff ? SW'(sum_in + SW'(diff)) : sum_in;
  end

  assign tok_out = tok_r;
  assign sum_out = sum_r;

endmodule

[hdl/sds_best.sv]
// Window accumulator and best-candidate tracker at the end of the cell chain.
// Depends on sds_pkg (token_t, SCORE_START).
module sds_best #(
  parameter int PW = 16,
  parameter int SW = 12,
  parameter int UW = 5,
  parameter int MAX_WINDOW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  init,
  input  logic signed [PW-1:0]  dmin,
  input  logic signed [PW-1:0]  dmax,
  input  logic signed [PW-1:0]  up,
  input  sds_pkg::token_t       tok,
  input  logic [SW-1:0]         sum,
  output logic signed [PW-1:0]  best_d,
  output logic [UW-1:0]         best_ud,
  output logic                  done
);

  localparam int AW = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int BW = (AW > 16) ? AW : 16;

  logic [AW-1:0]        acc_r, tot;
  logic [BW-1:0]        best_r;
  logic signed [PW-1:0] bd_r, ed_r;
  logic [UW-1:0]        bud_r, eud_r;
  logic                 done_r;

  assign tot = tok.first ? AW'(sum) : AW'(acc_r + AW'(sum));

  // ed/eud follow the candidate order of the issuing sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (init) begin
      done_r <= 1'b0;
    end else if (tok.valid && tok.fin) begin
      done_r <= 1'b1;
    end
    if (init) begin
      best_r <= BW'(sds_pkg::SCORE_START);
      bd_r   <= '0;
      bud_r  <= UW'(up);
      ed_r   <= dmin;
      eud_r  <= '0;
    end else if (tok.valid) begin
      acc_r <= tot;
      if (tok.last) begin
        if (BW'(tot) < best_r) begin
          best_r <= BW'(tot);
          bd_r   <= ed_r;
          bud_r  <= eud_r;
        end
        if (ed_r == dmax) begin
          ed_r  <= dmin;
          eud_r <= UW'(eud_r + 1'b1);
        end else begin
          ed_r <= PW'(ed_r + 1);
        end
      end
    end
  end

  assign best_d  = bd_r;
  assign best_ud = bud_r;
  assign done    = done_r;

endmodule

[hdl/sds_checker.sv]
// Port-level checks for the SAD stereo disparity search unit.
// Depends on the top level's ports only; bound to it below.
module sds_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [9:0]        out_row,
  input logic [9:0]        out_col,
  input logic signed [7:0] out_disparity_x,
  input logic [3:0]        out_vertical_offset
);

  // reset leaves the block ready and with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_disparity_x) && $stable(out_vertical_offset))
    else $error("stalled result beat changed");

  // disparity never below the most negative searchable value
  a_disp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_disparity_x >= -8'sd64)
    else $error("disparity out of range");

endmodule

bind sad_stereo_disparity_search_unit sds_checker u_sds_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_row             (out_row),
  .out_col             (out_col),
  .out_disparity_x     (out_disparity_x),
  .out_vertical_offset (out_vertical_offset)
);

[sim/tb.sv]
// Self-checking testbench for sad_stereo_disparity_search_unit.
// Depends on hdl/sds_pkg.sv and the unit's RTL. Directed table first, then random
// frames; every map entry is checked against an in-bench SAD search or typed values.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_W     = 1024;
  localparam int MAX_H     = 1024;
  localparam int MAX_WIN   = 16;
  localparam int MAX_DISP  = 64;
  localparam int MAX_VERT  = 4;
  localparam int ROWS_HELD = MAX_WIN + 2 * MAX_VERT;
  localparam int STALL_CAP = 20000;
  localparam int DRAIN_CYC = 60;
  localparam int HOLD_CYC  = 500;

  // pixel content of a frame
  localparam int PAT_TEXTURE = 0;
  localparam int PAT_EXTREME = 1;
  localparam int PAT_ZERO    = 2;

  typedef struct packed {
    logic [9:0]        row;
    logic [9:0]        col;
    logic signed [7:0] disp;
    logic [3:0]        voff;
  } map_entry_t;

  // one directed phase: raw register values, beats to send (0 = whole frame)
  typedef struct {
    int win, dmin, dmax, vr, thr, wd, ht;
    int npix;
    int pat;
    bit typed;
    int tdisp, tvoff;
  } phase_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_left_pixel;
  logic [7:0]        in_right_pixel;
  logic [7:0]        in_edge_strength;
  logic              out_valid;
  logic              out_stall;
  logic [9:0]        out_row;
  logic [9:0]        out_col;
  logic signed [7:0] out_disparity_x;
  logic [3:0]        out_vertical_offset;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [10:0]       cfg_data;

  sad_stereo_disparity_search_unit dut (.*);

  // shadow of the unit's state
  logic [7:0]  left_rows  [ROWS_HELD*MAX_W];
  logic [7:0]  right_rows [ROWS_HELD*MAX_W];
  logic [7:0]  edge_rows  [ROWS_HELD*MAX_W];
  logic [10:0] reg_shadow [7];
  int          row_ctr, col_ctr;

  map_entry_t  entry_q [$];
  int          errors;
  bit          idle_on;
  bit          hold_req;
  bit          typed_on;
  int          typed_disp, typed_voff;
  logic [7:0]  texture [40][160];
  int          tex_dy, tex_dx;

  phase_t dir_tab [11] = '{
    // tall single column, no search: defaults everywhere
    '{1, 0, 0, 0, 255, 1, 2047, 8, PAT_TEXTURE, 1, 0, 0},
    // height to zero mid-frame ends the frame after one more beat
    '{1, 0, 0, 0, 255, 1, 0, 1, PAT_TEXTURE, 1, 0, 0},
    // wide single row, extreme pixels, no search
    '{1, 0, 0, 0, 255, 2047, 1, 8, PAT_EXTREME, 1, 0, 0},
    '{1, 0, 0, 0, 255, 0, 1, 1, PAT_EXTREME, 1, 0, 0},
    // largest window, searched
    '{16, 0, 0, 0, 0, 16, 16, 0, PAT_TEXTURE, 0, 0, 0},
    // window zero, most negative minimum, largest maximum
    '{0, -64, 64, 0, 0, 129, 1, 0, PAT_TEXTURE, 0, 0, 0},
    // oversized maximum disparity, positive minimum
    '{1, 5, 127, 0, 0, 65, 1, 0, PAT_TEXTURE, 0, 0, 0},
    // oversized vertical range
    '{1, 0, 0, 7, 0, 1, 9, 0, PAT_TEXTURE, 0, 0, 0},
    '{2, -2, 3, 1, 128, 8, 6, 0, PAT_TEXTURE, 0, 0, 0},
    // right side all zero, left saturated; windows off the left edge
    '{2, -1, 2, 1, 0, 6, 5, 0, PAT_EXTREME, 0, 0, 0},
    // flat image: first candidate wins
    '{3, 0, 2, 0, 0, 6, 4, 0, PAT_ZERO, 1, 0, 0}
  };

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int slot(int r, int c);
    return (r % ROWS_HELD) * MAX_W + c;
  endfunction

  function automatic int eff_width();
    return clampi(int'(reg_shadow[sds_pkg::REG_WIDTH]), 1, MAX_W);
  endfunction

  function automatic int eff_height();
    return clampi(int'(reg_shadow[sds_pkg::REG_HEIGHT]), 1, MAX_H);
  endfunction

  // store one pixel; run the SAD search for a completed map entry above threshold
  task automatic predict_pixel(logic [7:0] lp, logic [7:0] rp, logic [7:0] ep);
    int w, dmin, dmax, up, lower, i, j, ud, d, a, b, lc, rc, lv, rv;
    int unsigned sum, best;
    int best_d, best_y;
    map_entry_t e;
    w     = clampi(int'(reg_shadow[sds_pkg::REG_WINDOW]), 1, MAX_WIN);
    dmin  = clampi(int'($signed(reg_shadow[sds_pkg::REG_DMIN][6:0])), -MAX_DISP, 0);
    dmax  = clampi(int'(reg_shadow[sds_pkg::REG_DMAX]), 0, MAX_DISP);
    up    = clampi(int'(reg_shadow[sds_pkg::REG_VRANGE]), 0, MAX_VERT);
    lower = -dmin;
    left_rows[slot(row_ctr, col_ctr)]  = lp;
    right_rows[slot(row_ctr, col_ctr)] = rp;
    edge_rows[slot(row_ctr, col_ctr)]  = ep;
    i = row_ctr - (w + 2 * up - 1);
    j = col_ctr - (w + dmax - 1);
    if (i >= 0 && j >= lower) begin
      best   = 65532;
      best_d = 0;
      best_y = up;
      if (edge_rows[slot(i, j)] > reg_shadow[sds_pkg::REG_THRESH][7:0]) begin
        for (ud = 0; ud <= 2 * up; ud++) begin
          for (d = dmin; d <= dmax; d++) begin
            sum = 0;
            for (a = 0; a < w; a++) begin
              for (b = 0; b < w; b++) begin
                lc = j + dmin + b;
                rc = j + dmin + d + b;
                lv = left_rows[slot(i + up + a, lc)];
                rv = rc < 0 ? 0 : right_rows[slot(i + ud + a, rc)];
                sum += lv > rv ? lv - rv : rv - lv;
              end
            end
            if (sum < best) begin
              best   = sum;
              best_d = d;
              best_y = ud;
            end
          end
        end
      end
      e.row  = 10'(i);
      e.col  = 10'(j - lower);
      e.disp = typed_on ? 8'(typed_disp) : 8'(best_d);
      e.voff = typed_on ? 4'(typed_voff) : 4'(best_y);
      entry_q.push_back(e);
    end
    if (col_ctr + 1 >= eff_width()) begin
      col_ctr = 0;
      row_ctr = row_ctr + 1 >= eff_height() ? 0 : row_ctr + 1;
    end else begin
      col_ctr = col_ctr + 1;
    end
  endtask

  // one register write beat; caller lowers cfg_valid afterwards
  task automatic write_reg(logic [2:0] idx, int value);
    logic [10:0] masked;
    case (idx)
      sds_pkg::REG_WINDOW: masked = 11'(value & 'h1F);
      sds_pkg::REG_DMIN:   masked = 11'(value & 'h7F);
      sds_pkg::REG_DMAX:   masked = 11'(value & 'h7F);
      sds_pkg::REG_VRANGE: masked = 11'(value & 'h7);
      sds_pkg::REG_THRESH: masked = 11'(value & 'hFF);
      default:             masked = 11'(value & 'h7FF);
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= masked;
    do @(posedge clk); while (!cfg_ready);
    reg_shadow[idx] = masked;
  endtask

  task automatic configure(int win, int dmin, int dmax, int vr, int thr, int wd, int ht);
    while (entry_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    write_reg(sds_pkg::REG_WINDOW, win);
    write_reg(sds_pkg::REG_DMIN, dmin);
    write_reg(sds_pkg::REG_DMAX, dmax);
    write_reg(sds_pkg::REG_VRANGE, vr);
    write_reg(sds_pkg::REG_THRESH, thr);
    write_reg(sds_pkg::REG_WIDTH, wd);
    write_reg(sds_pkg::REG_HEIGHT, ht);
    cfg_valid <= 1'b0;
  endtask

  // one input beat, with a random gap in front of it
  task automatic push_pixel(logic [7:0] lp, logic [7:0] rp, logic [7:0] ep);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < 25) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_left_pixel    <= lp;
    in_right_pixel   <= rp;
    in_edge_strength <= ep;
    do @(posedge clk); while (in_stall);
    predict_pixel(lp, rp, ep);
  endtask

  // right image is the left one shifted by a hidden offset, plus some noise
  task automatic send_pixels(int npix, int pat);
    int r, c;
    logic [7:0] lp, rp;
    for (int k = 0; k < npix; k++) begin
      r = row_ctr;
      c = col_ctr;
      case (pat)
        PAT_EXTREME: push_pixel(8'hFF, 8'h00, 8'hFF);
        PAT_ZERO:    push_pixel(8'h00, 8'h00, 8'($urandom_range(1, 255)));
        default: begin
          lp = texture[(r + 8) % 40][(c + 80) % 160];
          rp = texture[(r + 8 - tex_dy) % 40][(c + 80 - tex_dx) % 160];
          if ($urandom_range(7) == 0) rp = 8'($urandom);
          push_pixel(lp, rp, 8'($urandom));
        end
      endcase
    end
    in_valid <= 1'b0;
  endtask

  task automatic new_texture(int dy, int dx);
    foreach (texture[a, b]) texture[a][b] = 8'($urandom);
    tex_dy = dy;
    tex_dx = dx;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stall, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else begin
        out_stall <= idle_on && $urandom_range(99) < 25;
      end
    end
  end

  // result check against the oldest waiting entry
  always @(posedge clk) begin
    map_entry_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (entry_q.size() == 0) begin
        $display("%0t: unexpected map entry row %0d col %0d", $time, out_row, out_col);
        errors++;
      end else begin
        e = entry_q.pop_front();
        if (out_row !== e.row) begin
          $display("%0t: row exp %0d got %0d", $time, e.row, out_row);
          errors++;
        end
        if (out_col !== e.col) begin
          $display("%0t: col exp %0d got %0d", $time, e.col, out_col);
          errors++;
        end
        if (out_disparity_x !== e.disp) begin
          $display("%0t: disparity at (%0d,%0d) exp %0d got %0d",
                   $time, e.row, e.col, e.disp, out_disparity_x);
          errors++;
        end
        if (out_vertical_offset !== e.voff) begin
          $display("%0t: vertical offset at (%0d,%0d) exp %0d got %0d",
                   $time, e.row, e.col, e.voff, out_vertical_offset);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  int quiet_cyc;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= STALL_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  // main sequence
  initial begin
    int items, frames, n, w, dmin, dmax, vr, wd, ht;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_left_pixel    = '0;
    in_right_pixel   = '0;
    in_edge_strength = '0;
    cfg_valid        = 1'b0;
    cfg_index        = sds_pkg::REG_WINDOW;
    cfg_data         = '0;
    idle_on          = 1'b1;
    hold_req         = 1'b0;
    typed_on         = 1'b0;
    row_ctr          = 0;
    col_ctr          = 0;
    reg_shadow = '{11'(sds_pkg::RST_WINDOW), 11'(sds_pkg::RST_DMIN),
                   11'(sds_pkg::RST_DMAX), 11'(sds_pkg::RST_VRANGE),
                   11'(sds_pkg::RST_THRESH), sds_pkg::RST_WIDTH, sds_pkg::RST_HEIGHT};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed phases
    items = 0;
    foreach (dir_tab[k]) begin
      configure(dir_tab[k].win, dir_tab[k].dmin, dir_tab[k].dmax, dir_tab[k].vr,
                dir_tab[k].thr, dir_tab[k].wd, dir_tab[k].ht);
      new_texture($urandom_range(0, 2), $urandom_range(0, 3));
      typed_on   = dir_tab[k].typed;
      typed_disp = dir_tab[k].tdisp;
      typed_voff = dir_tab[k].tvoff;
      // every beat of the first phase gives a result, so a long hold fills the block
      if (k == 0) hold_req = 1'b1;
      n = dir_tab[k].npix == 0 ? eff_width() * eff_height() : dir_tab[k].npix;
      send_pixels(n, dir_tab[k].pat);
      items += n;
      typed_on = 1'b0;
    end

    // random whole frames with small geometry
    frames = 0;
    while (items < 1000) begin
      w    = $urandom_range(1, 4);
      dmin = -int'($urandom_range(0, 3));
      dmax = $urandom_range(0, 4);
      vr   = $urandom_range(0, 2);
      wd   = w + dmax - dmin + $urandom_range(0, 5);
      ht   = w + 2 * vr + $urandom_range(0, 3);
      configure(w, dmin, dmax, vr, $urandom_range(0, 255), wd, ht);
      new_texture($urandom_range(0, 2 * vr), $urandom_range(0, dmax - dmin) + dmin);
      idle_on = (frames >= 3);
      send_pixels(wd * ht, $urandom_range(0, 9) == 0 ? PAT_EXTREME : PAT_TEXTURE);
      items += wd * ht;
      frames++;
    end

    while (entry_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
